>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the LRU frame replacer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lfr_pkg.sv
// Package with sizes, operation codes and link write type of the LRU frame replacer.
package lfr_pkg;

  localparam int FRAMES  = 64;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int PTR_W   = FRAME_W + 1;
  localparam int COUNT_W = $clog2(FRAMES + 1);

  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(FRAMES);

  typedef enum logic [1:0] {
    OP_VICTIM = 2'd0,
    OP_PIN    = 2'd1,
    OP_UNPIN  = 2'd2
  } op_e;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    logic [PTR_W-1:0]   data;
  } link_wr_t;

endpackage

>>> rtl/lfr_link_mem.sv
// Older and newer link memories with a bypass of the last write.
module lfr_link_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lfr_pkg::FRAME_W-1:0]    rd_older_addr_i,
  input  logic [lfr_pkg::FRAME_W-1:0]    rd_newer_addr_i,
  input  lfr_pkg::link_wr_t              wr_older_i,
  input  lfr_pkg::link_wr_t              wr_newer_i,
  output logic [lfr_pkg::PTR_W-1:0]      rd_older_o,
  output logic [lfr_pkg::PTR_W-1:0]      rd_newer_o
);
  import lfr_pkg::*;

  logic [PTR_W-1:0]   older_mem [FRAMES];
  logic [PTR_W-1:0]   newer_mem [FRAMES];
  logic [PTR_W-1:0]   older_rd_q, newer_rd_q;
  logic [FRAME_W-1:0] older_addr_q, newer_addr_q;
  link_wr_t           older_byp_q, newer_byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_older_i.en) begin
      older_mem[wr_older_i.addr] <= wr_older_i.data;
    end
    if (wr_newer_i.en) begin
      newer_mem[wr_newer_i.addr] <= wr_newer_i.data;
    end
    older_rd_q   <= older_mem[rd_older_addr_i];
    newer_rd_q   <= newer_mem[rd_newer_addr_i];
    older_addr_q <= rd_older_addr_i;
    newer_addr_q <= rd_newer_addr_i;
  end

  // write landing on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_byp_q <= '0;
      newer_byp_q <= '0;
    end else begin
      older_byp_q <= wr_older_i;
      newer_byp_q <= wr_newer_i;
    end
  end

  assign rd_older_o = (older_byp_q.en && older_byp_q.addr == older_addr_q) ?
                      older_byp_q.data : older_rd_q;
  assign rd_newer_o = (newer_byp_q.en && newer_byp_q.addr == newer_addr_q) ?
                      newer_byp_q.data : newer_rd_q;

endmodule

>>> rtl/lru_frame_replacer.sv
// Top level of the LRU frame replacer: doubly linked list of evictable frames.
// Pipeline: a transaction accepted at an edge is registered in v_q, then in done_q, which
// strobes done_o with its result.
// Throughput: one transaction per cycle, busy_o stays low; link memory reads happen at
// the accept edge and the list update and result register load in the following cycle.
// Reset: the set is empty and no result is pending; link memories hold no reset value.
module lru_frame_replacer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    op_i,
  input  logic [lfr_pkg::FRAME_W-1:0]   frame_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [lfr_pkg::FRAME_W-1:0]   victim_frame_o,
  output logic [lfr_pkg::COUNT_W-1:0]   evictable_count_o
);
  import lfr_pkg::*;
  `include "assert_macros.svh"

  logic               accept;
  logic               v_q;
  op_e                op_q;
  logic [FRAME_W-1:0] frame_q;

  logic [FRAMES-1:0]  in_set_q, in_set_d;
  logic [PTR_W-1:0]   newest_q, newest_d;
  logic [PTR_W-1:0]   oldest_q, oldest_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic               done_q;
  logic               found_q, found_d;
  logic [FRAME_W-1:0] victim_q, victim_d;
  logic [COUNT_W-1:0] count_out_q;

  logic [FRAME_W-1:0] rd_older_addr, rd_newer_addr;
  logic [PTR_W-1:0]   rd_older, rd_newer;
  link_wr_t           wr_older, wr_newer;

  logic               rm;
  logic [FRAME_W-1:0] rm_frame;
  logic [PTR_W-1:0]   lnk_o, lnk_n;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign rd_older_addr = frame_i;
  assign rd_newer_addr = (op_e'(op_i) == OP_VICTIM) ? oldest_d[FRAME_W-1:0] : frame_i;

  lfr_link_mem u_link_mem (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rd_older_addr_i (rd_older_addr),
    .rd_newer_addr_i (rd_newer_addr),
    .wr_older_i      (wr_older),
    .wr_newer_i      (wr_newer),
    .rd_older_o      (rd_older),
    .rd_newer_o      (rd_newer)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      frame_q <= frame_i;
    end
  end

  always_comb begin
    newest_d = newest_q;
    oldest_d = oldest_q;
    in_set_d = in_set_q;
    count_d  = count_q;
    wr_older = '0;
    wr_newer = '0;
    found_d  = 1'b0;
    victim_d = '0;
    rm       = 1'b0;
    rm_frame = '0;
    lnk_o    = NONE_PTR;
    lnk_n    = NONE_PTR;
    if (v_q) begin
      case (op_q)
        OP_VICTIM: begin
          if (oldest_q != NONE_PTR) begin
            rm       = 1'b1;
            rm_frame = oldest_q[FRAME_W-1:0];
            lnk_n    = (oldest_q == newest_q) ? NONE_PTR : rd_newer;
            found_d  = 1'b1;
            victim_d = oldest_q[FRAME_W-1:0];
          end
        end
        OP_PIN: begin
          if (in_set_q[frame_q]) begin
            rm       = 1'b1;
            rm_frame = frame_q;
            lnk_o    = (PTR_W'(frame_q) == oldest_q) ? NONE_PTR : rd_older;
            lnk_n    = (PTR_W'(frame_q) == newest_q) ? NONE_PTR : rd_newer;
          end
        end
        OP_UNPIN: begin
          if (!in_set_q[frame_q]) begin
            wr_older = '{en: 1'b1, addr: frame_q, data: newest_q};
            if (newest_q != NONE_PTR) begin
              wr_newer = '{en: 1'b1, addr: newest_q[FRAME_W-1:0], data: PTR_W'(frame_q)};
            end else begin
              oldest_d = PTR_W'(frame_q);
            end
            newest_d          = PTR_W'(frame_q);
            in_set_d[frame_q] = 1'b1;
            count_d           = count_q + COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    if (rm) begin
      if (lnk_n != NONE_PTR) begin
        wr_older = '{en: 1'b1, addr: lnk_n[FRAME_W-1:0], data: lnk_o};
      end else begin
        newest_d = lnk_o;
      end
      if (lnk_o != NONE_PTR) begin
        wr_newer = '{en: 1'b1, addr: lnk_o[FRAME_W-1:0], data: lnk_n};
      end else begin
        oldest_d = lnk_n;
      end
      in_set_d[rm_frame] = 1'b0;
      count_d            = count_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_set_q <= '0;
      newest_q <= NONE_PTR;
      oldest_q <= NONE_PTR;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      in_set_q <= in_set_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
      done_q   <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q) begin
      found_q     <= found_d;
      victim_q    <= victim_d;
      count_out_q <= count_d;
    end
  end

  assign done_o            = done_q;
  assign found_o           = found_q;
  assign victim_frame_o    = victim_q;
  assign evictable_count_o = count_out_q;

  `LFR_ASSERT(a_count_matches_set, $countones(in_set_q) == 32'(count_q), "count differs from set")
  `LFR_ASSERT(a_ends_agree, (newest_q == NONE_PTR) == (oldest_q == NONE_PTR), "list ends disagree")
  `LFR_ASSERT(a_empty_has_no_ends, (count_q == '0) == (oldest_q == NONE_PTR), "empty list has ends")
  `LFR_ASSERT_NEXT(a_result_follows, v_q, done_o, "result strobe missing")
  `LFR_ASSERT(a_victim_removed, !(done_o && found_o) || !in_set_q[victim_q], "victim still in set")

endmodule
